>>> rtl/vn_pkg.sv
// vn_pkg: shared constants for the vector normalizer.
// Depends on nothing; used by vector_normalizer_top, vn_sqrt_cell and vn_div_cell.
package vn_pkg;
	localparam int unsigned DIM_BITS = 3;
	localparam logic [DIM_BITS-1:0] DIM_RESET = 3'd3;
	localparam int unsigned NUM_COMP = 4;
	localparam logic [0:0] REG_DIMENSION = 1'b0;
endpackage

>>> rtl/vn_sqrt_cell.sv
// vn_sqrt_cell: one stage of the restoring square root chain, two radicand bits per cell.
// Depends on vn_pkg for component count.
module vn_sqrt_cell #(
	parameter int unsigned SUM_BITS  = 34,
	parameter int unsigned ROOT_BITS = 17,
	parameter int unsigned MAG_BITS  = 16,
	parameter int unsigned IDX       = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    adv,
	input  logic                                    vld_in,
	input  logic [SUM_BITS-1:0]                     rem_in,
	input  logic [ROOT_BITS-1:0]                    root_in,
	input  logic [vn_pkg::NUM_COMP*MAG_BITS-1:0]    mag_in,
	input  logic [vn_pkg::NUM_COMP-1:0]             neg_in,
	output logic                                    vld_out,
	output logic [SUM_BITS-1:0]                     rem_out,
	output logic [ROOT_BITS-1:0]                    root_out,
	output logic [vn_pkg::NUM_COMP*MAG_BITS-1:0]    mag_out,
	output logic [vn_pkg::NUM_COMP-1:0]             neg_out
);
	// Bit-by-bit root: trial = (root<<2|1) shifted to this cell's position.
	localparam int unsigned SH = 2 * IDX;
	logic [SUM_BITS+1:0] trial;
	logic                fits;

	always_comb begin
		trial = ({2'b00, SUM_BITS'(root_in)} << 2 | (SUM_BITS+2)'(1)) << SH;
		fits  = ({2'b00, rem_in} >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_out  <= fits ? SUM_BITS'({2'b00, rem_in} - trial) : rem_in;
			root_out <= {root_in[ROOT_BITS-2:0], fits};
			mag_out  <= mag_in;
			neg_out  <= neg_in;
		end
	end
endmodule

>>> rtl/vn_div_cell.sv
// vn_div_cell: one stage of the restoring divider chain, one quotient bit per cell per lane.
// Depends on vn_pkg for component count.
module vn_div_cell #(
	parameter int unsigned MAG_BITS  = 16,
	parameter int unsigned ROOT_BITS = 17,
	parameter int unsigned Q_BITS    = 31,
	parameter int unsigned IDX       = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 vld_in,
	input  logic [ROOT_BITS-1:0]                 div_in,
	input  logic [vn_pkg::NUM_COMP*Q_BITS-1:0]   rem_in,
	input  logic [vn_pkg::NUM_COMP*Q_BITS-1:0]   quo_in,
	input  logic [vn_pkg::NUM_COMP-1:0]          neg_in,
	output logic                                 vld_out,
	output logic [ROOT_BITS-1:0]                 div_out,
	output logic [vn_pkg::NUM_COMP*Q_BITS-1:0]   rem_out,
	output logic [vn_pkg::NUM_COMP*Q_BITS-1:0]   quo_out,
	output logic [vn_pkg::NUM_COMP-1:0]          neg_out
);
	// Dividend numerator bits enter MSB first; cell IDX handles bit Q_BITS-1-IDX.
	localparam int unsigned W = Q_BITS + 1;
	logic [vn_pkg::NUM_COMP*Q_BITS-1:0] rem_nx;
	logic [vn_pkg::NUM_COMP*Q_BITS-1:0] quo_nx;

	always_comb begin
		logic [W-1:0] part;
		logic [W-1:0] dv;
		rem_nx = rem_in;
		quo_nx = quo_in;
		dv = W'(div_in);
		for (int l = 0; l < int'(vn_pkg::NUM_COMP); l++) begin
			// partial remainder lives in the low bits of rem; numerator bits in quo
			part = {rem_in[l*Q_BITS +: Q_BITS], quo_in[l*Q_BITS + Q_BITS-1]};
			quo_nx[l*Q_BITS +: Q_BITS] = {quo_in[l*Q_BITS +: Q_BITS-1], 1'b0};
			if (part >= dv) begin
				rem_nx[l*Q_BITS +: Q_BITS] = Q_BITS'(part - dv);
				quo_nx[l*Q_BITS] = 1'b1;
			end else begin
				rem_nx[l*Q_BITS +: Q_BITS] = Q_BITS'(part);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_out <= div_in;
			rem_out <= rem_nx;
			quo_out <= quo_nx;
			neg_out <= neg_in;
		end
	end
endmodule

>>> rtl/vector_normalizer_top.sv
// vector_normalizer_top: length and unit vector of a 2..4 component fixed-point vector.
// Depends on vn_pkg, vn_sqrt_cell and vn_div_cell.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_ready  comp_x comp_y comp_z comp_w
//  result    out        out_valid/out_ready length unit_x..unit_w zero_vector
//  config    in         APB write          dimension (address 0)
//
// Stages: one item enters per cycle while the chain advances; the pipeline is 2 input stages,
// COMPONENT_BITS+1 root cells, COMPONENT_BITS+UNIT_FRACTION_BITS+1 divider cells and 1 output stage.
// The whole chain advances together: it holds when the output register is full
// and not taken, so throughput is one item per cycle with a ready sink.
// Reset clears all valid bits and sets dimension to 3; payload is not reset.
module vector_normalizer_top #(
	parameter int unsigned COMPONENT_BITS     = 16,
	parameter int unsigned UNIT_FRACTION_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COMPONENT_BITS-1:0]  comp_x,
	input  logic signed [COMPONENT_BITS-1:0]  comp_y,
	input  logic signed [COMPONENT_BITS-1:0]  comp_z,
	input  logic signed [COMPONENT_BITS-1:0]  comp_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COMPONENT_BITS:0]           length,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_x,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_y,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_z,
	output logic signed [UNIT_FRACTION_BITS+1:0] unit_w,
	output logic                              zero_vector,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [0:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	localparam int unsigned NC    = vn_pkg::NUM_COMP;
	localparam int unsigned MB    = COMPONENT_BITS;          // magnitude bits
	localparam int unsigned SQB   = 2 * MB;                  // one square
	localparam int unsigned SB    = SQB + 2;                 // sum of four squares
	localparam int unsigned RB    = MB + 1;                  // root bits
	localparam int unsigned NSQ   = SB / 2;                  // root cells
	localparam int unsigned QB    = MB + UNIT_FRACTION_BITS + 1; // quotient/numerator bits
	localparam int unsigned UB    = UNIT_FRACTION_BITS + 2;
	localparam int unsigned SAT_SH = (SB > 64) ? 64 : SB;    // sum clamp position

	// configuration register
	logic [vn_pkg::DIM_BITS-1:0] dim_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= vn_pkg::DIM_RESET;
		end else if (psel && penable && pwrite && paddr == vn_pkg::REG_DIMENSION) begin
			dim_q <= pwdata[vn_pkg::DIM_BITS-1:0];
		end
	end
	assign prdata = (paddr == vn_pkg::REG_DIMENSION) ? 32'(dim_q) : 32'd0;

	// whole chain moves when the output slot is free or being emptied
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: magnitudes, signs, lane enables
	logic [NC*MB-1:0] mag_s1;
	logic [NC-1:0]    neg_s1;
	logic             vld_s1;
	logic [NC-1:0]    use_c;
	logic signed [MB-1:0] comp_c [NC];

	always_comb begin
		comp_c[0] = comp_x;
		comp_c[1] = comp_y;
		comp_c[2] = comp_z;
		comp_c[3] = comp_w;
		use_c = 4'b0011;
		if (dim_q >= 3'd3) use_c[2] = 1'b1;
		if (dim_q >= 3'd4) use_c[3] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < int'(NC); l++) begin
				// unused lanes become zero so they drop out of sum and quotient
				mag_s1[l*MB +: MB] <= use_c[l] ?
					(comp_c[l][MB-1] ? MB'(-comp_c[l]) : MB'(comp_c[l])) : '0;
				neg_s1[l] <= use_c[l] & comp_c[l][MB-1];
			end
		end
	end

	// stage 2: squares (one multiplier per lane) and their sum
	logic [SB-1:0]    sum_s2;
	logic [NC*MB-1:0] mag_s2;
	logic [NC-1:0]    neg_s2;
	logic             vld_s2;
	logic [SQB-1:0]   sq_c [NC];
	logic [SB-1:0]    sum_c;

	always_comb begin
		for (int l = 0; l < int'(NC); l++) begin
			sq_c[l] = SQB'(mag_s1[l*MB +: MB]) * SQB'(mag_s1[l*MB +: MB]);
		end
		sum_c = SB'(sq_c[0]) + SB'(sq_c[1]) + SB'(sq_c[2]) + SB'(sq_c[3]);
		// a sum past 64 bits clamps to all ones in 64 bits
		if ((sum_c >> SAT_SH) != '0) sum_c = {SB{1'b1}} >> (SB - SAT_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_c;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// square root chain: cell k resolves root bit NSQ-1-k
	logic [SB-1:0]    sr_rem  [NSQ+1];
	logic [RB-1:0]    sr_root [NSQ+1];
	logic [NC*MB-1:0] sr_mag  [NSQ+1];
	logic [NC-1:0]    sr_neg  [NSQ+1];
	logic             sr_vld  [NSQ+1];

	assign sr_rem[0]  = sum_s2;
	assign sr_root[0] = '0;
	assign sr_mag[0]  = mag_s2;
	assign sr_neg[0]  = neg_s2;
	assign sr_vld[0]  = vld_s2;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		vn_sqrt_cell #(
			.SUM_BITS(SB), .ROOT_BITS(RB), .MAG_BITS(MB), .IDX(NSQ-1-k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(sr_vld[k]), .rem_in(sr_rem[k]), .root_in(sr_root[k]),
			.mag_in(sr_mag[k]), .neg_in(sr_neg[k]),
			.vld_out(sr_vld[k+1]), .rem_out(sr_rem[k+1]), .root_out(sr_root[k+1]),
			.mag_out(sr_mag[k+1]), .neg_out(sr_neg[k+1])
		);
	end

	// divider chain: numerator = mag << UNIT_FRACTION_BITS, divisor = root
	logic [RB-1:0]    dv_div [QB+1];
	logic [NC*QB-1:0] dv_rem [QB+1];
	logic [NC*QB-1:0] dv_quo [QB+1];
	logic [NC-1:0]    dv_neg [QB+1];
	logic             dv_vld [QB+1];

	always_comb begin
		for (int l = 0; l < int'(NC); l++) begin
			dv_quo[0][l*QB +: QB] = QB'(sr_mag[NSQ][l*MB +: MB]) << UNIT_FRACTION_BITS;
		end
	end
	assign dv_div[0] = sr_root[NSQ];
	assign dv_rem[0] = '0;
	assign dv_neg[0] = sr_neg[NSQ];
	assign dv_vld[0] = sr_vld[NSQ];

	for (genvar k = 0; k < QB; k++) begin : g_div
		vn_div_cell #(
			.MAG_BITS(MB), .ROOT_BITS(RB), .Q_BITS(QB), .IDX(k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(dv_vld[k]), .div_in(dv_div[k]), .rem_in(dv_rem[k]),
			.quo_in(dv_quo[k]), .neg_in(dv_neg[k]),
			.vld_out(dv_vld[k+1]), .div_out(dv_div[k+1]), .rem_out(dv_rem[k+1]),
			.quo_out(dv_quo[k+1]), .neg_out(dv_neg[k+1])
		);
	end

	// output stage: saturate, apply sign, force zeros on a zero vector
	localparam logic [QB-1:0] ONE_Q = QB'(1) << UNIT_FRACTION_BITS;
	logic [UB-1:0] unit_c [NC];
	logic          zero_c;

	always_comb begin
		logic [QB-1:0] q;
		zero_c = (dv_div[QB] == '0);
		for (int l = 0; l < int'(NC); l++) begin
			q = dv_quo[QB][l*QB +: QB];
			if (q > ONE_Q) q = ONE_Q;
			if (zero_c) q = '0;
			unit_c[l] = dv_neg[QB][l] ? UB'(-q) : UB'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			length      <= dv_div[QB];
			unit_x      <= unit_c[0];
			unit_y      <= unit_c[1];
			unit_z      <= unit_c[2];
			unit_w      <= unit_c[3];
			zero_vector <= zero_c;
		end
	end
endmodule

>>> rtl/vn_checker.sv
// vn_checker: port-level assertions for vector_normalizer_top, bound to it below.
// Depends on vector_normalizer_top port and parameter names only.
module vn_checker #(
	parameter int unsigned COMPONENT_BITS     = 16,
	parameter int unsigned UNIT_FRACTION_BITS = 14
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [COMPONENT_BITS:0]         length,
	input logic [UNIT_FRACTION_BITS+1:0]   unit_x,
	input logic [UNIT_FRACTION_BITS+1:0]   unit_z,
	input logic                            zero_vector
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready) else $error("input stalled with free slot");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(length)))
		else $error("result dropped under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_vector) |-> (length == '0 && unit_x == '0 && unit_z == '0))
		else $error("zero vector with nonzero outputs");
	a_nzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !zero_vector) |-> (length != '0)) else $error("flag mismatch");
endmodule

bind vector_normalizer_top vn_checker #(
	.COMPONENT_BITS(COMPONENT_BITS), .UNIT_FRACTION_BITS(UNIT_FRACTION_BITS)
) u_vn_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .length(length), .unit_x(unit_x), .unit_z(unit_z),
	.zero_vector(zero_vector)
);
